/* hdl/hstr_pkg.sv */
// Shared constants, types and codes of the half-space tile rasteriser.
package hstr_pkg;

    // Tile edge length in pixels and integer bits of a vertex coordinate.
    localparam int TILE_SIZE      = 8;
    localparam int COORD_INT_BITS = 12;

    // Vertex coordinate bits kept from a register (12.4, at most 16 bits).
    localparam int CW = (COORD_INT_BITS + 4 > 16) ? 16 : COORD_INT_BITS + 4;

    // Pixel index width, 12.4 pixel position width and tile counter width.
    localparam int PIX_W = 12;
    localparam int PX_W  = 16;
    localparam int TL    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;

    // Offset of the far tile corner in 12.4 units.
    localparam int CORNER_OFF = (TILE_SIZE - 1) * 16;

    // Arithmetic widths: coordinate difference, product, edge value.
    localparam int SW = PX_W + 1;
    localparam int PW = 2 * SW;
    localparam int EW = PW + 3;

    // Barycentric numerator, its magnitude, denominator and divisor widths.
    localparam int NUMS_W = PW + 1;
    localparam int NUM_W  = PW;
    localparam int DEN_W  = PW - 3;
    localparam int DVS_W  = DEN_W - 1;
    localparam int QW     = NUM_W + 1;

    // Weight, colour product and colour sum widths.
    localparam int LW  = QW + 2;
    localparam int CPW = LW + 9;
    localparam int CSW = CPW + 2;
    localparam int CH_W = 8;

    // Divider stages: one quotient bit per stage plus the sign stage.
    localparam int DIV_LAT = NUM_W + 1;

    // Cycles for the triangle set-up to settle after a register write.
    localparam int SETTLE   = 3;
    localparam int SETTLE_W = $clog2(SETTLE + 1);

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_A_POS = 3'd0,
        REG_B_POS = 3'd1,
        REG_C_POS = 3'd2,
        REG_A_COL = 3'd3,
        REG_B_COL = 3'd4,
        REG_C_COL = 3'd5
    } cfg_reg_t;

    // Tile classification codes.
    typedef enum logic [1:0] {
        CLS_OUT  = 2'd0,
        CLS_FULL = 2'd1,
        CLS_PART = 2'd2
    } tile_class_t;

    // Triangle set-up, derived from the vertex registers.
    typedef struct packed {
        logic [2:0][SW-1:0] edx;
        logic [2:0][SW-1:0] edy;
        logic [2:0][EW-1:0] ec;
        logic [PX_W-1:0]    vx2;
        logic [PX_W-1:0]    vy2;
        logic [SW-1:0]      y23;
        logic [SW-1:0]      x32;
        logic [SW-1:0]      y31;
        logic [SW-1:0]      x13;
        logic [DEN_W-1:0]   denom;
        logic [2:0][23:0]   col;
    } setup_t;

    // One pixel travelling down the pipeline.
    typedef struct packed {
        logic          valid;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        tile_class_t   cls;
        logic          last;
    } pix_item_t;

    // Pixel with its coverage decision.
    typedef struct packed {
        pix_item_t item;
        logic      cov;
        logic      col_en;
    } pix_side_t;

endpackage

/* hdl/hstr_setup.sv */
// Configuration registers and the pipelined triangle set-up.
module hstr_setup
    import hstr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        settled,
    output setup_t      setup
);

    logic [2:0][31:0] pos_reg;
    logic [2:0][23:0] col_reg;
    logic [SETTLE_W-1:0] settle_reg;

    logic [PX_W-1:0] vx [3];
    logic [PX_W-1:0] vy [3];

    logic [PX_W-1:0]        s1_vx_reg  [3];
    logic [PX_W-1:0]        s1_vy_reg  [3];
    logic signed [SW-1:0]   s1_edx_reg [3];
    logic signed [SW-1:0]   s1_edy_reg [3];
    logic signed [SW-1:0]   s1_x13_reg, s1_y13_reg, s1_y23_reg, s1_x32_reg;

    logic signed [PW-1:0]   s2_pa_reg [3];
    logic signed [PW-1:0]   s2_pb_reg [3];
    logic                   s2_tl_reg [3];
    logic signed [PW-1:0]   s2_dp1_reg, s2_dp2_reg;
    logic signed [SW-1:0]   s2_edx_reg [3];
    logic signed [SW-1:0]   s2_edy_reg [3];
    logic [PX_W-1:0]        s2_vx2_reg, s2_vy2_reg;
    logic signed [SW-1:0]   s2_y23_reg, s2_x32_reg, s2_y31_reg, s2_x13_reg;

    logic signed [EW-1:0]   s3_ec_reg [3];
    logic signed [DEN_W-1:0] s3_denom_reg;
    logic signed [SW-1:0]   s3_edx_reg [3];
    logic signed [SW-1:0]   s3_edy_reg [3];
    logic [PX_W-1:0]        s3_vx2_reg, s3_vy2_reg;
    logic signed [SW-1:0]   s3_y23_reg, s3_x32_reg, s3_y31_reg, s3_x13_reg;

    // Every write is taken at once.
    assign cfg_ready = 1'b1;

    // Register file; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_A_POS: pos_reg[0] <= cfg_data;
                REG_B_POS: pos_reg[1] <= cfg_data;
                REG_C_POS: pos_reg[2] <= cfg_data;
                REG_A_COL: col_reg[0] <= cfg_data[23:0];
                REG_B_COL: col_reg[1] <= cfg_data[23:0];
                REG_C_COL: col_reg[2] <= cfg_data[23:0];
                default:   ;
            endcase
        end
    end

    // Tiles are held off until the set-up stages reflect the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(SETTLE);
        else if (cfg_valid)
            settle_reg <= SETTLE_W'(SETTLE);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - 1'b1;
    end

    assign settled = (settle_reg == '0);

    // Coordinates keep their low bits only.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vx[k] = PX_W'(pos_reg[k][16 +: CW]);
            vy[k] = PX_W'(pos_reg[k][0 +: CW]);
        end
    end

    // Stage one: edge and barycentric differences.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_vx_reg[k]  <= vx[k];
            s1_vy_reg[k]  <= vy[k];
            s1_edx_reg[k] <= $signed({1'b0, vx[k]}) - $signed({1'b0, vx[(k + 1) % 3]});
            s1_edy_reg[k] <= $signed({1'b0, vy[k]}) - $signed({1'b0, vy[(k + 1) % 3]});
        end
        s1_x13_reg <= $signed({1'b0, vx[0]}) - $signed({1'b0, vx[2]});
        s1_y13_reg <= $signed({1'b0, vy[0]}) - $signed({1'b0, vy[2]});
        s1_y23_reg <= $signed({1'b0, vy[1]}) - $signed({1'b0, vy[2]});
        s1_x32_reg <= $signed({1'b0, vx[2]}) - $signed({1'b0, vx[1]});
    end

    // Stage two: products for the edge constants and the denominator, and the top-left flags.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_pa_reg[k]  <= s1_edy_reg[k] * $signed({1'b0, s1_vx_reg[k]});
            s2_pb_reg[k]  <= s1_edx_reg[k] * $signed({1'b0, s1_vy_reg[k]});
            s2_tl_reg[k]  <= s1_edy_reg[k][SW-1]
                             || (s1_edy_reg[k] == '0 && s1_edx_reg[k] > 0);
            s2_edx_reg[k] <= s1_edx_reg[k];
            s2_edy_reg[k] <= s1_edy_reg[k];
        end
        s2_dp1_reg <= s1_y23_reg * s1_x13_reg;
        s2_dp2_reg <= s1_x32_reg * s1_y13_reg;
        s2_vx2_reg <= s1_vx_reg[2];
        s2_vy2_reg <= s1_vy_reg[2];
        s2_y23_reg <= s1_y23_reg;
        s2_x32_reg <= s1_x32_reg;
        s2_y31_reg <= -s1_y13_reg;
        s2_x13_reg <= s1_x13_reg;
    end

    // Stage three: edge constants with the top-left rule, and the denominator.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_ec_reg[k]  <= EW'(s2_pa_reg[k]) - EW'(s2_pb_reg[k])
                             + $signed({{(EW-1){1'b0}}, s2_tl_reg[k]});
            s3_edx_reg[k] <= s2_edx_reg[k];
            s3_edy_reg[k] <= s2_edy_reg[k];
        end
        s3_denom_reg <= DEN_W'(s2_dp1_reg >>> 4) + DEN_W'(s2_dp2_reg >>> 4);
        s3_vx2_reg   <= s2_vx2_reg;
        s3_vy2_reg   <= s2_vy2_reg;
        s3_y23_reg   <= s2_y23_reg;
        s3_x32_reg   <= s2_x32_reg;
        s3_y31_reg   <= s2_y31_reg;
        s3_x13_reg   <= s2_x13_reg;
    end

    // Gather the set-up for the tile and pixel pipelines.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            setup.edx[k] = s3_edx_reg[k];
            setup.edy[k] = s3_edy_reg[k];
            setup.ec[k]  = s3_ec_reg[k];
            setup.col[k] = col_reg[k];
        end
        setup.vx2   = s3_vx2_reg;
        setup.vy2   = s3_vy2_reg;
        setup.y23   = s3_y23_reg;
        setup.x32   = s3_x32_reg;
        setup.y31   = s3_y31_reg;
        setup.x13   = s3_x13_reg;
        setup.denom = s3_denom_reg;
    end

endmodule

/* hdl/hstr_tile.sv */
// Tile front end: corner classification and the pixel sequencer.
module hstr_tile
    import hstr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tile_valid,
    output logic        tile_ready,
    input  logic [8:0]  tile_col,
    input  logic [8:0]  tile_row,
    input  logic        settled,
    input  setup_t      setup,
    input  logic        take,
    output pix_item_t   item
);

    logic                 t1_valid_reg, t2_valid_reg, t3_valid_reg, gen_valid_reg;
    logic [PIX_W-1:0]     t1_x0_reg, t1_y0_reg, t2_x0_reg, t2_y0_reg, t3_x0_reg, t3_y0_reg;
    logic signed [PW-1:0] t2_ea_reg [3];
    logic signed [PW-1:0] t2_eb_reg [3];
    logic signed [EW-1:0] t3_e_reg  [3];

    logic [PIX_W-1:0] gx0_reg, gy0_reg;
    tile_class_t      gcls_reg;
    logic [TL-1:0]    gi_reg, gj_reg;

    logic t1_free, t2_free, t3_free, gen_free, gen_last, accept;
    logic [PX_W-1:0] px0, py0;
    logic signed [EW-1:0] dxo [3];
    logic signed [EW-1:0] dyo [3];
    logic [3:0]  amask [3];
    tile_class_t cls;

    // Stage hand-over: a stage moves on when the next one is free.
    assign gen_last = (gi_reg == TL'(TILE_SIZE - 1)) && (gj_reg == TL'(TILE_SIZE - 1));
    assign gen_free = !gen_valid_reg || (gen_last && take);
    assign t3_free  = !t3_valid_reg || gen_free;
    assign t2_free  = !t2_valid_reg || t3_free;
    assign t1_free  = !t1_valid_reg || t2_free;

    assign tile_ready = t1_free && settled;
    assign accept     = tile_valid && tile_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            gen_valid_reg <= 1'b0;
            gi_reg        <= '0;
            gj_reg        <= '0;
        end
        else
        begin
            if (t1_free)
                t1_valid_reg <= accept;
            if (t2_free)
                t2_valid_reg <= t1_valid_reg;
            if (t3_free)
                t3_valid_reg <= t2_valid_reg;
            if (gen_free)
            begin
                gen_valid_reg <= t3_valid_reg;
                gi_reg        <= '0;
                gj_reg        <= '0;
            end
            else if (take)
            begin
                if (gi_reg == TL'(TILE_SIZE - 1))
                begin
                    gi_reg <= '0;
                    gj_reg <= gj_reg + 1'b1;
                end
                else
                    gi_reg <= gi_reg + 1'b1;
            end
        end
    end

    // Stage one: the tile's first pixel.
    always_ff @(posedge clk)
    begin
        if (t1_free && accept)
        begin
            t1_x0_reg <= PIX_W'(tile_col * TILE_SIZE);
            t1_y0_reg <= PIX_W'(tile_row * TILE_SIZE);
        end
    end

    assign px0 = {t1_x0_reg, 4'b0000};
    assign py0 = {t1_y0_reg, 4'b0000};

    // Stage two: edge products at the first corner.
    always_ff @(posedge clk)
    begin
        if (t2_free)
        begin
            t2_x0_reg <= t1_x0_reg;
            t2_y0_reg <= t1_y0_reg;
            for (int k = 0; k < 3; k++)
            begin
                t2_ea_reg[k] <= $signed(setup.edx[k]) * $signed({1'b0, py0});
                t2_eb_reg[k] <= $signed(setup.edy[k]) * $signed({1'b0, px0});
            end
        end
    end

    // Stage three: edge values at the first corner.
    always_ff @(posedge clk)
    begin
        if (t3_free)
        begin
            t3_x0_reg <= t2_x0_reg;
            t3_y0_reg <= t2_y0_reg;
            for (int k = 0; k < 3; k++)
                t3_e_reg[k] <= $signed(setup.ec[k]) + EW'(t2_ea_reg[k]) - EW'(t2_eb_reg[k]);
        end
    end

    // Remaining corners by constant offsets, then the tile class.
    always_comb
    begin
        cls = CLS_FULL;
        for (int k = 0; k < 3; k++)
        begin
            dxo[k] = EW'($signed(setup.edx[k])) * EW'(CORNER_OFF);
            dyo[k] = EW'($signed(setup.edy[k])) * EW'(CORNER_OFF);
            amask[k][0] = t3_e_reg[k] > 0;
            amask[k][1] = (t3_e_reg[k] - dyo[k]) > 0;
            amask[k][2] = (t3_e_reg[k] + dxo[k]) > 0;
            amask[k][3] = (t3_e_reg[k] + dxo[k] - dyo[k]) > 0;
        end
        if (amask[0] == 4'h0 || amask[1] == 4'h0 || amask[2] == 4'h0)
            cls = CLS_OUT;
        else if (amask[0] != 4'hF || amask[1] != 4'hF || amask[2] != 4'hF)
            cls = CLS_PART;
    end

    // Sequencer holding the tile whose pixels are being issued.
    always_ff @(posedge clk)
    begin
        if (gen_free && t3_valid_reg)
        begin
            gx0_reg  <= t3_x0_reg;
            gy0_reg  <= t3_y0_reg;
            gcls_reg <= cls;
        end
    end

    assign item.valid = gen_valid_reg;
    assign item.x     = gx0_reg + PIX_W'(gi_reg);
    assign item.y     = gy0_reg + PIX_W'(gj_reg);
    assign item.cls   = gcls_reg;
    assign item.last  = gen_last;

endmodule

/* hdl/hstr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, signed result.
module hstr_div
    import hstr_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num_mag,
    input  logic                    neg,
    input  logic [DVS_W-1:0]        dvs,
    output logic signed [QW-1:0]    quo
);

    logic [DVS_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] q_reg   [NUM_W];
    logic             neg_reg [NUM_W];
    logic signed [QW-1:0] quo_reg;

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_step
        logic [DVS_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] q_in;
        logic             neg_in;
        logic [DVS_W:0]   trial;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num_mag;
            assign q_in   = '0;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign fits  = trial >= {1'b0, dvs};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
                num_reg[s] <= {num_in[NUM_W-2:0], 1'b0};
                q_reg[s]   <= {q_in[NUM_W-2:0], fits};
                neg_reg[s] <= neg_in;
            end
        end
    end

    // Apply the sign, truncating towards zero.
    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= neg_reg[NUM_W-1] ? -$signed(QW'(q_reg[NUM_W-1]))
                                        : $signed(QW'(q_reg[NUM_W-1]));
    end

    assign quo = quo_reg;

endmodule

/* hdl/hstr_pixel.sv */
// Per-pixel pipeline: edge tests, barycentric weights, colour and output register.
module hstr_pixel
    import hstr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  setup_t            setup,
    input  pix_item_t         item,
    output logic              take,
    output logic              pixel_valid,
    input  logic              pixel_ready,
    output logic [PIX_W-1:0]  pixel_x,
    output logic [PIX_W-1:0]  pixel_y,
    output logic              covered,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue,
    output logic [1:0]        tile_class,
    output logic              last_of_tile
);

    logic en;

    pix_item_t p1_side_reg;
    pix_side_t p2_side_reg, c1_side_reg, c2_side_reg, c3_side_reg;
    pix_side_t sd_reg [DIV_LAT];

    logic signed [PW-1:0] p1_ea_reg [3];
    logic signed [PW-1:0] p1_eb_reg [3];
    logic signed [PW-1:0] p1_b1_reg, p1_b2_reg, p1_b3_reg, p1_b4_reg;

    logic [NUM_W-1:0] p2_m1_reg, p2_m2_reg;
    logic             p2_n1_reg, p2_n2_reg;

    logic signed [LW-1:0]  c1_l_reg [3];
    logic signed [CPW-1:0] c2_p_reg [3][3];
    logic signed [CSW-1:0] c3_s_reg [3];

    logic             out_valid_reg, out_cov_reg, out_last_reg;
    logic [PIX_W-1:0] out_x_reg, out_y_reg;
    logic [CH_W-1:0]  out_rgb_reg [3];
    tile_class_t      out_cls_reg;

    logic [PX_W-1:0]       px, py;
    logic signed [SW-1:0]  dxp, dyp;
    logic signed [EW-1:0]  e [3];
    logic                  all_pos, cov;
    logic signed [NUMS_W-1:0] n1, n2;
    logic [NUMS_W-1:0]     m1, m2;
    logic                  dneg;
    logic [DEN_W-1:0]      dmag;
    logic [DVS_W-1:0]      dvs;
    logic signed [QW-1:0]  q1, q2;
    logic signed [CSW-1:0] sh [3];
    logic [CH_W-1:0]       sat [3];

    // The whole pipeline advances unless a finished pixel waits at the output.
    assign en   = !out_valid_reg || pixel_ready;
    assign take = en;

    // Control: items and valid bits move one stage per enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_side_reg   <= '0;
            p2_side_reg   <= '0;
            c1_side_reg   <= '0;
            c2_side_reg   <= '0;
            c3_side_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++)
                sd_reg[s] <= '0;
        end
        else if (en)
        begin
            p1_side_reg   <= item;
            p2_side_reg   <= '{item: p1_side_reg, cov: cov, col_en: cov && (setup.denom != '0)};
            sd_reg[0]     <= p2_side_reg;
            for (int s = 1; s < DIV_LAT; s++)
                sd_reg[s] <= sd_reg[s-1];
            c1_side_reg   <= sd_reg[DIV_LAT-1];
            c2_side_reg   <= c1_side_reg;
            c3_side_reg   <= c2_side_reg;
            out_valid_reg <= c3_side_reg.item.valid;
        end
    end

    // Stage one: pixel position, edge and barycentric products.
    assign px  = {item.x, 4'b0000};
    assign py  = {item.y, 4'b0000};
    assign dxp = $signed({1'b0, px}) - $signed({1'b0, setup.vx2});
    assign dyp = $signed({1'b0, py}) - $signed({1'b0, setup.vy2});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p1_ea_reg[k] <= $signed(setup.edx[k]) * $signed({1'b0, py});
                p1_eb_reg[k] <= $signed(setup.edy[k]) * $signed({1'b0, px});
            end
            p1_b1_reg <= $signed(setup.y23) * dxp;
            p1_b2_reg <= $signed(setup.x32) * dyp;
            p1_b3_reg <= $signed(setup.y31) * dxp;
            p1_b4_reg <= $signed(setup.x13) * dyp;
        end
    end

    // Stage two: edge tests, coverage and divider operands.
    always_comb
    begin
        all_pos = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            e[k] = $signed(setup.ec[k]) + EW'(p1_ea_reg[k]) - EW'(p1_eb_reg[k]);
            if (!(e[k] > 0))
                all_pos = 1'b0;
        end
        case (p1_side_reg.cls)
            CLS_FULL: cov = 1'b1;
            CLS_PART: cov = all_pos;
            default:  cov = 1'b0;
        endcase
        n1 = (NUMS_W'(p1_b1_reg >>> 4) + NUMS_W'(p1_b2_reg >>> 4)) <<< 4;
        n2 = (NUMS_W'(p1_b3_reg >>> 4) + NUMS_W'(p1_b4_reg >>> 4)) <<< 4;
        m1 = n1[NUMS_W-1] ? NUMS_W'(-n1) : NUMS_W'(n1);
        m2 = n2[NUMS_W-1] ? NUMS_W'(-n2) : NUMS_W'(n2);
    end

    // The divisor is the triangle's denominator magnitude.
    assign dneg = setup.denom[DEN_W-1];
    assign dmag = dneg ? DEN_W'(-$signed(setup.denom)) : setup.denom;
    assign dvs  = dmag[DVS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_m1_reg <= m1[NUM_W-1:0];
            p2_m2_reg <= m2[NUM_W-1:0];
            p2_n1_reg <= n1[NUMS_W-1] ^ dneg;
            p2_n2_reg <= n2[NUMS_W-1] ^ dneg;
        end
    end

    // Two weight dividers run side by side.
    hstr_div u_div_l1
    (
        .clk     (clk),
        .en      (en),
        .num_mag (p2_m1_reg),
        .neg     (p2_n1_reg),
        .dvs     (dvs),
        .quo     (q1)
    );

    hstr_div u_div_l2
    (
        .clk     (clk),
        .en      (en),
        .num_mag (p2_m2_reg),
        .neg     (p2_n2_reg),
        .dvs     (dvs),
        .quo     (q2)
    );

    // Colour stage one: the three weights, the third from the first two.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_l_reg[0] <= LW'(q1);
            c1_l_reg[1] <= LW'(q2);
            c1_l_reg[2] <= LW'(16) - LW'(q1) - LW'(q2);
        end
    end

    // Colour stage two: weight times vertex channel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                for (int c = 0; c < 3; c++)
                    c2_p_reg[k][c] <= c1_l_reg[k]
                                      * $signed({1'b0, setup.col[k][23 - 8 * c -: 8]});
        end
    end

    // Colour stage three: channel sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                c3_s_reg[c] <= CSW'(c2_p_reg[0][c]) + CSW'(c2_p_reg[1][c])
                               + CSW'(c2_p_reg[2][c]);
        end
    end

    // Drop the fraction and saturate each channel.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sh[c] = c3_s_reg[c] >>> 4;
            if (sh[c] < 0)
                sat[c] = '0;
            else if (sh[c] > 255)
                sat[c] = '1;
            else
                sat[c] = sh[c][CH_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg    <= c3_side_reg.item.x;
            out_y_reg    <= c3_side_reg.item.y;
            out_cls_reg  <= c3_side_reg.item.cls;
            out_last_reg <= c3_side_reg.item.last;
            out_cov_reg  <= c3_side_reg.cov;
            for (int c = 0; c < 3; c++)
                out_rgb_reg[c] <= c3_side_reg.col_en ? sat[c] : '0;
        end
    end

    assign pixel_valid  = out_valid_reg;
    assign pixel_x      = out_x_reg;
    assign pixel_y      = out_y_reg;
    assign covered      = out_cov_reg;
    assign red          = out_rgb_reg[0];
    assign green        = out_rgb_reg[1];
    assign blue         = out_rgb_reg[2];
    assign tile_class   = out_cls_reg;
    assign last_of_tile = out_last_reg;

endmodule

/* hdl/half_space_tile_rasterizer_unit.sv */
// Top level of the half-space tile rasteriser.
//
// Each tile transfer yields one pixel transfer per cycle while the output
// is not stalled, for the 8x8 pixels of a tile; the pixel sequencer issues
// one pixel a cycle, and the next tile is taken while the current one is
// still being issued. A tile reaches the sequencer through tile stages t1,
// t2 and t3, and its first pixel reaches the output through edge stages p1
// and p2, the 35-stage weight dividers, three colour stages and the
// output register. After a register write, tiles are held off until the
// triangle set-up stages reflect the new registers. A stall at the output
// holds the whole pixel pipeline in place.
module half_space_tile_rasterizer_unit
    import hstr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              tile_valid,
    output logic              tile_ready,
    input  logic [8:0]        tile_col,
    input  logic [8:0]        tile_row,
    output logic              pixel_valid,
    input  logic              pixel_ready,
    output logic [PIX_W-1:0]  pixel_x,
    output logic [PIX_W-1:0]  pixel_y,
    output logic              covered,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue,
    output logic [1:0]        tile_class,
    output logic              last_of_tile
);

    setup_t    setup;
    logic      settled;
    logic      take;
    pix_item_t item;

    // Registers and triangle set-up.
    hstr_setup u_setup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .settled   (settled),
        .setup     (setup)
    );

    // Tile classification and pixel sequencing.
    hstr_tile u_tile
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .settled    (settled),
        .setup      (setup),
        .take       (take),
        .item       (item)
    );

    // Per-pixel coverage and colour.
    hstr_pixel u_pixel
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .setup        (setup),
        .item         (item),
        .take         (take),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .covered      (covered),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .tile_class   (tile_class),
        .last_of_tile (last_of_tile)
    );

endmodule

/* sim/tb_half_space_tile_rasterizer_unit.sv */
// Self-checking testbench of the half-space tile rasteriser: tile and register transfers in, pixel results checked.
`timescale 1ns / 100ps

module tb_half_space_tile_rasterizer_unit;
    import hstr_pkg::*;

    // Index beyond the register file, used to check that such writes are ignored.
    localparam logic [2:0] REG_NONE = 3'd6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    // One pixel result as the block presents it.
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             cov;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [1:0]       cls;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
    } tile_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic tile_valid;
    logic tile_ready;
    logic [8:0] tile_col;
    logic [8:0] tile_row;
    logic pixel_valid;
    logic pixel_ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic covered;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [1:0] tile_class;
    logic last_of_tile;

    tile_t      tile_q[$];
    reg_write_t reg_write_q[$];
    pixel_t     pixel_exp_q[$];
    logic [31:0] vertex_regs[6];
    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int idle_cycles;

    half_space_tile_rasterizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tile_valid   (tile_valid),
        .tile_ready   (tile_ready),
        .tile_col     (tile_col),
        .tile_row     (tile_row),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .covered      (covered),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .tile_class   (tile_class),
        .last_of_tile (last_of_tile)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor division by sixteen, rounding towards minus infinity.
    function automatic longint floor_div16(longint v);
        if (v >= 0)
            return v / 16;
        return -((-v + 15) / 16);
    endfunction

    function automatic longint clamp_channel(longint v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // Rasterise one tile against the current registers and queue its 64 pixel results.
    task automatic rasterise_tile(input logic [8:0] col, input logic [8:0] row);
        longint vx[3], vy[3], edx[3], edy[3], ec[3], ccol[3][3];
        longint tx, ty, denom, y23, x13, x32, y13, y31, px, py, l1, l2, l3, e;
        longint rgb[3];
        int nk, amask[3];
        tile_class_t cls;
        bit cov;
        pixel_t p;

        tx = longint'(col) * TILE_SIZE;
        ty = longint'(row) * TILE_SIZE;
        for (int k = 0; k < 3; k++)
        begin
            vx[k] = longint'(vertex_regs[k][31:16]) & ((64'd1 << CW) - 1);
            vy[k] = longint'(vertex_regs[k][15:0]) & ((64'd1 << CW) - 1);
            for (int c = 0; c < 3; c++)
                ccol[k][c] = longint'((vertex_regs[3 + k] >> (16 - 8 * c)) & 32'hFF);
        end

        // Edge constants with the top-left fill correction.
        for (int k = 0; k < 3; k++)
        begin
            nk = (k + 1) % 3;
            edx[k] = vx[k] - vx[nk];
            edy[k] = vy[k] - vy[nk];
            ec[k] = edy[k] * vx[k] - edx[k] * vy[k];
            if (edy[k] < 0 || (edy[k] == 0 && edx[k] > 0))
                ec[k] += 1;
        end

        // Classify the tile from its four corner pixels.
        for (int k = 0; k < 3; k++)
        begin
            amask[k] = 0;
            for (int i = 0; i < 4; i++)
            begin
                px = (tx + (i[0] ? TILE_SIZE - 1 : 0)) * 16;
                py = (ty + (i[1] ? TILE_SIZE - 1 : 0)) * 16;
                if (ec[k] + edx[k] * py - edy[k] * px > 0)
                    amask[k] |= 1 << i;
            end
        end
        cls = CLS_FULL;
        for (int k = 0; k < 3; k++)
            if (amask[k] == 0)
                cls = CLS_OUT;
        if (cls != CLS_OUT)
            for (int k = 0; k < 3; k++)
                if (amask[k] != 'hF)
                    cls = CLS_PART;

        y23 = vy[1] - vy[2];
        x13 = vx[0] - vx[2];
        x32 = vx[2] - vx[1];
        y13 = vy[0] - vy[2];
        y31 = vy[2] - vy[0];
        denom = floor_div16(y23 * x13) + floor_div16(x32 * y13);

        // Pixels in raster order with coverage and interpolated colour.
        for (int j = 0; j < TILE_SIZE; j++)
        begin
            for (int i = 0; i < TILE_SIZE; i++)
            begin
                px = (tx + i) * 16;
                py = (ty + j) * 16;
                cov = (cls != CLS_OUT);
                if (cls == CLS_PART)
                    for (int k = 0; k < 3; k++)
                    begin
                        e = ec[k] + edx[k] * py - edy[k] * px;
                        if (!(e > 0))
                            cov = 1'b0;
                    end
                rgb = '{0, 0, 0};
                if (cov && denom != 0)
                begin
                    l1 = (16 * (floor_div16(y23 * (px - vx[2]))
                              + floor_div16(x32 * (py - vy[2])))) / denom;
                    l2 = (16 * (floor_div16(y31 * (px - vx[2]))
                              + floor_div16(x13 * (py - vy[2])))) / denom;
                    l3 = 16 - l1 - l2;
                    for (int c = 0; c < 3; c++)
                        rgb[c] = clamp_channel(floor_div16(l1 * ccol[0][c] + l2 * ccol[1][c]
                                                           + l3 * ccol[2][c]));
                end
                p.x    = PIX_W'(tx + i);
                p.y    = PIX_W'(ty + j);
                p.cov  = cov;
                p.r    = rgb[0][7:0];
                p.g    = rgb[1][7:0];
                p.b    = rgb[2][7:0];
                p.cls  = cls;
                p.last = (i == TILE_SIZE - 1 && j == TILE_SIZE - 1);
                pixel_exp_q.push_back(p);
            end
        end
    endtask

    // Register write driver; the shadow registers follow each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            for (int k = 0; k < 6; k++)
                vertex_regs[k] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index <= REG_C_POS)
                    vertex_regs[cfg_index] <= cfg_data;
                else if (cfg_index <= REG_C_COL)
                    vertex_regs[cfg_index] <= cfg_data & 32'hFF_FFFF;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() > 0)
                begin
                    reg_write_t w;
                    w = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Tile driver with random gaps between transfers; tiles wait for pending register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_valid <= 1'b0;
            tile_col   <= '0;
            tile_row   <= '0;
        end
        else
        begin
            if (tile_valid && tile_ready)
                rasterise_tile(tile_col, tile_row);
            if (!tile_valid || tile_ready)
            begin
                if (tile_q.size() > 0 && reg_write_q.size() == 0 && !cfg_valid
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    tile_t t;
                    t = tile_q.pop_front();
                    tile_valid <= 1'b1;
                    tile_col   <= t.col;
                    tile_row   <= t.row;
                end
                else
                    tile_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: random back-pressure and an in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_ready <= 1'b0;
        else
        begin
            pixel_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (pixel_valid && pixel_ready)
            begin
                pixel_t got, want;
                got = '{pixel_x, pixel_y, covered, red, green, blue, tile_class, last_of_tile};
                if (pixel_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected pixel transfer: x %0d y %0d", pixel_x, pixel_y);
                end
                else
                begin
                    want = pixel_exp_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Pixel mismatch: expected x %0d y %0d cov %0d rgb %0d/%0d/%0d",
                                      " class %0d last %0d, got x %0d y %0d cov %0d",
                                      " rgb %0d/%0d/%0d class %0d last %0d"},
                                     want.x, want.y, want.cov, want.r, want.g, want.b,
                                     want.cls, want.last, got.x, got.y, got.cov, got.r,
                                     got.g, got.b, got.cls, got.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (tile_valid && tile_ready)
            || (pixel_valid && pixel_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        reg_write_q.push_back('{index, data});
    endtask

    task automatic push_tile(input logic [8:0] col, input logic [8:0] row);
        tile_q.push_back('{col, row});
    endtask

    // Wait until every transfer is done and the pipeline has emptied.
    task automatic drain;
        while (tile_q.size() > 0 || tile_valid || reg_write_q.size() > 0 || cfg_valid
               || pixel_exp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random triangle near the origin, its registers written in a random order.
    task automatic random_triangle;
        logic [31:0] vals[6];
        int order[6];
        int tmp, s;
        for (int k = 0; k < 3; k++)
        begin
            vals[k] = {16'($urandom_range(0, 767)), 16'($urandom_range(0, 767))};
            vals[3 + k] = $urandom;
            order[k] = k;
            order[3 + k] = 3 + k;
        end
        for (int k = 5; k > 0; k--)
        begin
            s = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[s];
            order[s] = tmp;
        end
        for (int k = 0; k < 6; k++)
            write_reg(order[k][2:0], vals[order[k]]);
    endtask

    // Stimulus: directed triangles and tiles, then random phases with idling.
    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset: a degenerate triangle with no colour.
        push_tile(9'd0, 9'd0);
        push_tile(9'd511, 9'd511);
        drain();

        // Large right triangle: full, partial and outside tiles.
        write_reg(REG_A_POS, 32'h0000_0000);
        write_reg(REG_B_POS, 32'h0000_FFF0);
        write_reg(REG_C_POS, 32'hFFF0_0000);
        write_reg(REG_A_COL, 32'hFF_0000);
        write_reg(REG_B_COL, 32'h00_FF00);
        write_reg(REG_C_COL, 32'h00_00FF);
        push_tile(9'd0, 9'd0);
        push_tile(9'd1, 9'd1);
        push_tile(9'd255, 9'd255);
        push_tile(9'd256, 9'd255);
        push_tile(9'd511, 9'd0);
        push_tile(9'd0, 9'd511);
        push_tile(9'd511, 9'd511);
        push_tile(9'd170, 9'd85);
        drain();

        // Opposite winding, then extreme register values with ignored writes.
        write_reg(REG_B_POS, 32'hFFF0_0000);
        write_reg(REG_C_POS, 32'h0000_FFF0);
        push_tile(9'd1, 9'd1);
        push_tile(9'd85, 9'd170);
        drain();
        for (int k = 0; k < 6; k++)
            write_reg(k[2:0], 32'hFFFF_FFFF);
        write_reg(REG_NONE, 32'h1234_5678);
        write_reg(3'd7, 32'h8765_4321);
        push_tile(9'd511, 9'd511);
        push_tile(9'd0, 9'd0);
        drain();

        // Small triangle with white, black and mixed colours.
        write_reg(REG_A_POS, {16'd16, 16'd8});
        write_reg(REG_B_POS, {16'd200, 16'd120});
        write_reg(REG_C_POS, {16'd40, 16'd230});
        write_reg(REG_A_COL, 32'hFF_FFFF);
        write_reg(REG_B_COL, 32'h00_0000);
        write_reg(REG_C_COL, 32'h80_40C0);
        push_tile(9'd0, 9'd0);
        push_tile(9'd1, 9'd0);
        push_tile(9'd0, 9'd1);
        push_tile(9'd1, 9'd1);
        drain();

        // Random phases with different idling patterns.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int t = 0; t < 2; t++)
            begin
                random_triangle();
                for (int n = 0; n < 19; n++)
                begin
                    if ($urandom_range(99) < 85)
                        push_tile(9'($urandom_range(0, 6)), 9'($urandom_range(0, 6)));
                    else
                        push_tile(9'($urandom), 9'($urandom));
                end
                drain();
            end
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hstr_pkg.sv
hdl/hstr_setup.sv
hdl/hstr_tile.sv
hdl/hstr_div.sv
hdl/hstr_pixel.sv
hdl/half_space_tile_rasterizer_unit.sv
sim/tb_half_space_tile_rasterizer_unit.sv
